>>> rtl/bspc_pkg.sv
// Shared types, codes and reset constants for the bench supply panel controller.
// No dependencies; every other file of the block but bspc_chan_if imports this package.
package bspc_pkg;

  localparam int unsigned NUM_PRESETS = 4;
  localparam int unsigned KEY_COUNT   = 11;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned IDLE_W      = 10;
  localparam int unsigned CFG_IDX_W   = 3;

  // Key positions in the press and long-press masks.
  localparam int unsigned KEY_RANGE     = 4;
  localparam int unsigned KEY_VLIMIT    = 5;
  localparam int unsigned KEY_QUICK     = 6;
  localparam int unsigned KEY_OCP_NONE  = 7;
  localparam int unsigned KEY_OCP_CONT  = 8;
  localparam int unsigned KEY_OCP_ONCE  = 9;
  localparam int unsigned KEY_OUTPUT    = 10;

  localparam logic [IDLE_W-1:0]  RST_IDLE_TIMEOUT    = IDLE_W'(150);
  localparam logic [VALUE_W-1:0] RST_VOLTAGE_CAP     = VALUE_W'(840);
  localparam logic [VALUE_W-1:0] RST_QUICK_VOLTAGE   = VALUE_W'(500);
  localparam logic [VALUE_W-1:0] RST_DEFAULT_VOLTAGE = VALUE_W'(450);
  localparam logic [VALUE_W-1:0] RST_DEFAULT_CURRENT = VALUE_W'(5000);

  typedef enum logic [1:0] {
    CMD_KEY_TICK = 2'd0,
    CMD_SETPOINT = 2'd1,
    CMD_OCP_TRIP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OCP_NONE = 2'd0,
    OCP_CONT = 2'd1,
    OCP_ONCE = 2'd2
  } ocp_e;

  typedef enum logic [1:0] {
    BEEP_OFF      = 2'd0,
    BEEP_BRIEF    = 2'd1,
    BEEP_EXTENDED = 2'd2
  } beep_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIMEOUT    = 3'd0,
    CFG_VOLTAGE_CAP     = 3'd1,
    CFG_QUICK_VOLTAGE   = 3'd2,
    CFG_DEFAULT_VOLTAGE = 3'd3,
    CFG_DEFAULT_CURRENT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [KEY_COUNT-1:0] press_mask;
    logic [KEY_COUNT-1:0] long_mask;
    logic                 all_released;
    logic                 panel_locked;
    logic [VALUE_W-1:0]   new_voltage;
    logic [VALUE_W-1:0]   new_current;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] set_voltage;
    logic [VALUE_W-1:0] set_current;
    logic [1:0]         ocp_level;
    logic               output_on;
    logic               voltage_limit_on;
    logic               low_current_range;
    logic               voltage_pending;
    logic               current_pending;
    logic               voltage_reload;
    logic               current_reload;
    logic [1:0]         beep;
    logic               trip_cleared;
  } out_item_t;

  typedef struct packed {
    logic [IDLE_W-1:0]  idle_timeout;
    logic [VALUE_W-1:0] voltage_cap;
    logic [VALUE_W-1:0] quick_voltage;
    logic [VALUE_W-1:0] default_voltage;
    logic [VALUE_W-1:0] default_current;
  } cfg_t;

  // Index of the lowest set bit of a preset key group.
  function automatic logic [1:0] first_preset(input logic [NUM_PRESETS-1:0] mask);
    logic [1:0] idx;
    idx = '0;
    for (int k = NUM_PRESETS - 1; k >= 0; k--) begin
      if (mask[k]) begin
        idx = 2'(k);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/bspc_chan_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface bspc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/bspc_cfg.sv
// Configuration register file of the panel controller.
// Depends on bspc_pkg for register indexes, reset values and the cfg_t group.
module bspc_cfg
  import bspc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VALUE_W-1:0]   cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IDLE_TIMEOUT:    cfg_d.idle_timeout    = cfg_data_i[IDLE_W-1:0];
        CFG_VOLTAGE_CAP:     cfg_d.voltage_cap     = cfg_data_i;
        CFG_QUICK_VOLTAGE:   cfg_d.quick_voltage   = cfg_data_i;
        CFG_DEFAULT_VOLTAGE: cfg_d.default_voltage = cfg_data_i;
        CFG_DEFAULT_CURRENT: cfg_d.default_current = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout    <= RST_IDLE_TIMEOUT;
      cfg_q.voltage_cap     <= RST_VOLTAGE_CAP;
      cfg_q.quick_voltage   <= RST_QUICK_VOLTAGE;
      cfg_q.default_voltage <= RST_DEFAULT_VOLTAGE;
      cfg_q.default_current <= RST_DEFAULT_CURRENT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/bspc_core.sv
// Panel state and the single-pass decision logic for one beat.
// Depends on bspc_pkg; state advances only when step_i is high.
module bspc_core
  import bspc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [VALUE_W-1:0] vset_q, vset_d, iset_q, iset_d, saved_v_q, saved_v_d;
  ocp_e               mode_q, mode_d;
  logic               out_en_q, out_en_d, vcap_q, vcap_d, range_q, range_d;
  logic               pend_v_q, pend_v_d, pend_c_q, pend_c_d;
  logic               trip_q, trip_d, latch_q, latch_d;
  logic [IDLE_W-1:0]  idle_q, idle_d;
  logic [VALUE_W-1:0] pre_v_q [NUM_PRESETS];
  logic [VALUE_W-1:0] pre_v_d [NUM_PRESETS];
  logic [VALUE_W-1:0] pre_c_q [NUM_PRESETS];
  logic [VALUE_W-1:0] pre_c_d [NUM_PRESETS];
  ocp_e               pre_m_q [NUM_PRESETS];
  ocp_e               pre_m_d [NUM_PRESETS];

  logic        vrel, crel, tclr, done;
  beep_e       beep;
  logic [1:0]  rec_idx, sav_idx;
  logic [NUM_PRESETS-1:0] press_pre, long_pre;

  assign press_pre = item_i.press_mask[NUM_PRESETS-1:0];
  assign long_pre  = item_i.long_mask[NUM_PRESETS-1:0];
  assign rec_idx   = first_preset(press_pre);
  assign sav_idx   = first_preset(long_pre);

  always_comb begin
    vset_d    = vset_q;
    iset_d    = iset_q;
    saved_v_d = saved_v_q;
    mode_d    = mode_q;
    out_en_d  = out_en_q;
    vcap_d    = vcap_q;
    range_d   = range_q;
    pend_v_d  = pend_v_q;
    pend_c_d  = pend_c_q;
    trip_d    = trip_q;
    latch_d   = latch_q;
    idle_d    = idle_q;
    pre_v_d   = pre_v_q;
    pre_c_d   = pre_c_q;
    pre_m_d   = pre_m_q;
    vrel      = 1'b0;
    crel      = 1'b0;
    tclr      = 1'b0;
    done      = 1'b0;
    beep      = BEEP_OFF;

    case (cmd_e'(item_i.command))
      CMD_SETPOINT: begin
        vset_d   = item_i.new_voltage;
        iset_d   = item_i.new_current;
        pend_v_d = 1'b1;
        pend_c_d = 1'b1;
        vrel     = 1'b1;
        crel     = 1'b1;
      end
      CMD_OCP_TRIP: begin
        if (mode_q != OCP_NONE) begin
          trip_d   = 1'b1;
          out_en_d = 1'b0;
        end
      end
      CMD_KEY_TICK: begin
        // Released tick: unlock key actions and run the pending-flag timer.
        if (item_i.all_released) begin
          latch_d = 1'b0;
          if (pend_v_q || pend_c_q) begin
            if (idle_q <= IDLE_W'(1)) begin
              idle_d   = cfg_i.idle_timeout;
              pend_v_d = 1'b0;
              pend_c_d = 1'b0;
            end else begin
              idle_d = idle_q - IDLE_W'(1);
            end
          end
        end
        if (!latch_d && !item_i.panel_locked) begin
          done = 1'b1;
          if (|press_pre) begin
            vset_d   = pre_v_q[rec_idx];
            iset_d   = pre_c_q[rec_idx];
            mode_d   = OCP_CONT;
            pend_v_d = 1'b1;
            pend_c_d = 1'b1;
            vrel     = 1'b1;
            crel     = 1'b1;
            beep     = BEEP_BRIEF;
          end else if (|long_pre) begin
            pre_v_d[sav_idx] = vset_q;
            pre_c_d[sav_idx] = iset_q;
            pre_m_d[sav_idx] = mode_q;
            beep             = BEEP_EXTENDED;
          end else if (item_i.press_mask[KEY_RANGE]) begin
            range_d = !range_q;
            beep    = BEEP_BRIEF;
          end else if (item_i.press_mask[KEY_VLIMIT]) begin
            if (!vcap_q) begin
              vcap_d    = 1'b1;
              saved_v_d = vset_q;
              if (vset_q > cfg_i.voltage_cap) begin
                vset_d = cfg_i.voltage_cap;
              end
            end else begin
              vcap_d = 1'b0;
              vset_d = saved_v_q;
            end
            pend_v_d = 1'b1;
            vrel     = 1'b1;
            beep     = BEEP_BRIEF;
          end else if (item_i.press_mask[KEY_QUICK]) begin
            vset_d   = cfg_i.quick_voltage;
            pend_v_d = 1'b1;
            vrel     = 1'b1;
            beep     = BEEP_BRIEF;
          end else if (item_i.press_mask[KEY_OCP_NONE]) begin
            if (mode_q != OCP_NONE) begin
              tclr   = trip_q;
              trip_d = 1'b0;
              mode_d = OCP_NONE;
            end
            beep = BEEP_BRIEF;
          end else if (item_i.press_mask[KEY_OCP_CONT]) begin
            case (mode_q)
              OCP_NONE: mode_d = OCP_CONT;
              OCP_CONT: begin
                tclr   = trip_q;
                trip_d = 1'b0;
                mode_d = OCP_NONE;
              end
              OCP_ONCE: begin
                tclr   = trip_q;
                trip_d = 1'b0;
                mode_d = OCP_CONT;
              end
              default: ;
            endcase
            beep = BEEP_BRIEF;
          end else if (item_i.press_mask[KEY_OCP_ONCE]) begin
            case (mode_q)
              OCP_NONE: mode_d = OCP_ONCE;
              OCP_CONT: begin
                tclr   = trip_q;
                trip_d = 1'b0;
                mode_d = OCP_ONCE;
              end
              OCP_ONCE: begin
                if (trip_q) begin
                  tclr   = 1'b1;
                  trip_d = 1'b0;
                end else begin
                  mode_d = OCP_NONE;
                end
              end
              default: ;
            endcase
            beep = BEEP_BRIEF;
          end else if (item_i.press_mask[KEY_OUTPUT]) begin
            if (out_en_q) begin
              out_en_d = 1'b0;
            end else if (!(mode_q == OCP_ONCE && trip_q)) begin
              out_en_d = 1'b1;
              vrel     = 1'b1;
              crel     = 1'b1;
            end
            beep = BEEP_BRIEF;
          end else begin
            done = 1'b0;
          end
          if (done) begin
            latch_d = 1'b1;
          end
          // Factory reset acts alongside any other key and leaves the latch alone.
          if (item_i.long_mask[KEY_OUTPUT]) begin
            vset_d = cfg_i.default_voltage;
            iset_d = cfg_i.default_current;
            for (int k = 0; k < NUM_PRESETS; k++) begin
              pre_v_d[k] = cfg_i.default_voltage;
              pre_c_d[k] = cfg_i.default_current;
              pre_m_d[k] = OCP_CONT;
            end
            mode_d   = OCP_NONE;
            vcap_d   = 1'b0;
            range_d  = 1'b0;
            out_en_d = 1'b0;
            beep     = BEEP_EXTENDED;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vset_q    <= RST_DEFAULT_VOLTAGE;
      iset_q    <= RST_DEFAULT_CURRENT;
      saved_v_q <= '0;
      mode_q    <= OCP_NONE;
      out_en_q  <= 1'b0;
      vcap_q    <= 1'b0;
      range_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      pend_c_q  <= 1'b0;
      trip_q    <= 1'b0;
      latch_q   <= 1'b0;
      idle_q    <= RST_IDLE_TIMEOUT;
      for (int k = 0; k < NUM_PRESETS; k++) begin
        pre_v_q[k] <= RST_DEFAULT_VOLTAGE;
        pre_c_q[k] <= RST_DEFAULT_CURRENT;
        pre_m_q[k] <= OCP_CONT;
      end
    end else if (step_i) begin
      vset_q    <= vset_d;
      iset_q    <= iset_d;
      saved_v_q <= saved_v_d;
      mode_q    <= mode_d;
      out_en_q  <= out_en_d;
      vcap_q    <= vcap_d;
      range_q   <= range_d;
      pend_v_q  <= pend_v_d;
      pend_c_q  <= pend_c_d;
      trip_q    <= trip_d;
      latch_q   <= latch_d;
      idle_q    <= idle_d;
      pre_v_q   <= pre_v_d;
      pre_c_q   <= pre_c_d;
      pre_m_q   <= pre_m_d;
    end
  end

  always_comb begin
    result_o.set_voltage       = vset_d;
    result_o.set_current       = iset_d;
    result_o.ocp_level         = mode_d;
    result_o.output_on         = out_en_d;
    result_o.voltage_limit_on  = vcap_d;
    result_o.low_current_range = range_d;
    result_o.voltage_pending   = pend_v_d;
    result_o.current_pending   = pend_c_d;
    result_o.voltage_reload    = vrel;
    result_o.current_reload    = crel;
    result_o.beep              = beep;
    result_o.trip_cleared      = tclr;
  end

endmodule

>>> rtl/bench_supply_panel_controller.sv
// Top level of the bench supply front-panel controller: input register, result register.
// Depends on bspc_pkg, bspc_chan_if, bspc_cfg and bspc_core.
//
// Usage: every beat on in_i is one panel event: a key scan tick with debounced
// short- and long-press masks, an external setpoint write, or an overcurrent trip.
// For each accepted beat exactly one result beat leaves on out_o, carrying the
// setpoints, OCP mode, output and range flags after that event plus the one-shot
// reload, beep and trip-cleared indications it caused.
// Configuration registers are written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user writes them only while no beat is in flight; the block does not enforce it.
// A beat accepted into the input register is decided from there, and its result is
// registered in the result register, which drives out_o.
// Throughput: one beat per cycle while out_o is not stalled; the whole decision is one
// short combinational pass from the input register to the result register.
// Reset clears the valid flags of both pipeline registers and puts setpoints, presets,
// modes and configuration at their power-on values.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat, so in_i drops ready only once both are full.
module bench_supply_panel_controller
  import bspc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bspc_chan_if.sink            in_i,
  bspc_chan_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VALUE_W-1:0]   cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_item_q;
  out_item_t out_item_q, result;
  logic      in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic      advance, in_fire, step;

  bspc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register is free when empty or when its beat is taken this cycle.
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;
  // The held beat is decided, and the panel state updated, as it moves on.
  assign step       = in_valid_q && advance;

  bspc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_i.payload;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule
